### design/segment_box_nearest_hit_macros.svh
// Assertion macros shared by the checker
`ifndef SEGMENT_BOX_NEAREST_HIT_MACROS_SVH
`define SEGMENT_BOX_NEAREST_HIT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define SBNH_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbnh check failed");

// Next-cycle implication, sampled on clk, quiet during reset
`define SBNH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbnh check failed");

`endif

### design/sbnh_pkg.sv
`default_nettype none
package sbnh_pkg;

  localparam int unsigned CFG_ADDR_BITS = 5;

  typedef enum logic [2:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_END_X   = 3'd2,
    REG_END_Y   = 3'd3,
    REG_LAYER   = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_STORE,
    ST_SLAB,
    ST_DECIDE,
    ST_MX,
    ST_MY,
    ST_SQX,
    ST_SQY,
    ST_RINIT,
    ST_ROOT,
    ST_MD,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

### design/segment_box_nearest_hit.sv
// Channel  Direction  Handshake            Word
// in_      into       in_valid / in_stall  one box, last_box closes a query
// out_     out of     out_valid / out_stall one nearest-hit result per query
// cfg_     into       APB psel/penable     segment end points and layer mask
//
// A box that takes part passes four slab quotients through one restoring
// divider of T_FRAC_BITS+2 steps, plus set-up and compare steps; a parallel
// axis skips its two quotients. A skipped box goes straight to the decide step.
// A last box with a hit adds five passes through one shared multiplier and
// COORD_BITS+1 steps of the bit-serial square root.
// Synchronous active-low reset clears the sequencer, running best and config.
// in_stall is high while a box is in work; a result waits in the output
// register under out_stall and the next box is still taken meanwhile.
`default_nettype none
module segment_box_nearest_hit #(
  parameter int COORD_BITS  = 24,
  parameter int T_FRAC_BITS = 16,
  parameter int ID_BITS     = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [COORD_BITS-1:0]          in_box_min_x,
  input  logic signed [COORD_BITS-1:0]          in_box_min_y,
  input  logic signed [COORD_BITS-1:0]          in_box_max_x,
  input  logic signed [COORD_BITS-1:0]          in_box_max_y,
  input  logic [7:0]                            in_box_layer,
  input  logic                                  in_box_enabled,
  input  logic [ID_BITS-1:0]                    in_box_id,
  input  logic                                  in_last_box,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_hit_found,
  output logic [ID_BITS-1:0]                    out_hit_id,
  output logic [T_FRAC_BITS:0]                  out_hit_t,
  output logic signed [COORD_BITS-1:0]          out_hit_x,
  output logic signed [COORD_BITS-1:0]          out_hit_y,
  output logic [COORD_BITS:0]                   out_hit_distance,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [sbnh_pkg::CFG_ADDR_BITS-1:0]    cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;
  localparam int TF   = T_FRAC_BITS;
  localparam int QB   = TF + 2;
  localparam int TW   = TF + 3;
  localparam int NW   = DW + TF;
  localparam int RMW  = DW + 1;
  localparam int MW   = (CW + 2 > TF + 2) ? CW + 2 : TF + 2;
  localparam int PW   = 2 * MW;
  localparam int RW   = DW;
  localparam int SW   = 2 * RW;
  localparam int RRW  = RW + 2;
  localparam int NSTEP = (RW > QB) ? RW : QB;
  localparam int CNTW = $clog2(NSTEP + 1);

  localparam logic signed [TW-1:0] T_ONE  = {2'b00, 1'b1, {TF{1'b0}}};
  localparam logic signed [TW-1:0] T_SAT  = {2'b00, 1'b1, {(TF-1){1'b0}}, 1'b1};
  localparam logic signed [TW-1:0] T_TWO  = {1'b0, 1'b1, {(TF+1){1'b0}}};
  localparam logic signed [TW-1:0] T_NEG  = {TW{1'b1}};
  localparam logic signed [TW-1:0] T_ZERO = {TW{1'b0}};

  // configuration
  logic [CW-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [7:0]    layer_r;
  logic          cfg_wr;
  logic [2:0]    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r    <= '0;
      sy_r    <= '0;
      ex_r    <= '0;
      ey_r    <= '0;
      layer_r <= 8'hFF;
    end else if (cfg_wr) begin
      case (cfg_idx)
        sbnh_pkg::REG_START_X: sx_r    <= cfg_pwdata[CW-1:0];
        sbnh_pkg::REG_START_Y: sy_r    <= cfg_pwdata[CW-1:0];
        sbnh_pkg::REG_END_X:   ex_r    <= cfg_pwdata[CW-1:0];
        sbnh_pkg::REG_END_Y:   ey_r    <= cfg_pwdata[CW-1:0];
        sbnh_pkg::REG_LAYER:   layer_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      sbnh_pkg::REG_START_X: cfg_prdata = 32'(sx_r);
      sbnh_pkg::REG_START_Y: cfg_prdata = 32'(sy_r);
      sbnh_pkg::REG_END_X:   cfg_prdata = 32'(ex_r);
      sbnh_pkg::REG_END_Y:   cfg_prdata = 32'(ey_r);
      sbnh_pkg::REG_LAYER:   cfg_prdata = 32'(layer_r);
      default:               cfg_prdata = '0;
    endcase
  end

  // sequencer and datapath registers
  sbnh_pkg::state_t state_r, state_nxt;
  logic [1:0]            k_r, k_nxt;
  logic [CNTW-1:0]       cnt_r, cnt_nxt;
  logic signed [CW-1:0]  bminx_r, bminy_r, bmaxx_r, bmaxy_r;
  logic signed [CW-1:0]  bminx_nxt, bminy_nxt, bmaxx_nxt, bmaxy_nxt;
  logic [ID_BITS-1:0]    id_r, id_nxt;
  logic                  last_r, last_nxt;
  logic                  ok_r, ok_nxt;
  logic signed [TW-1:0]  t1_r, t1_nxt, t2_r, t2_nxt, tres_r, tres_nxt;
  logic signed [TW-1:0]  tmin_r, tmin_nxt, tmax_r, tmax_nxt;
  logic [DW-1:0]         dd_r, dd_nxt;
  logic [RMW-1:0]        rem_r, rem_nxt;
  logic [QB-1:0]         low_r, low_nxt, quo_r, quo_nxt;
  logic signed [TW-1:0]  best_t_r, best_t_nxt;
  logic [ID_BITS-1:0]    best_id_r, best_id_nxt;
  logic                  best_valid_r, best_valid_nxt;
  logic signed [PW-1:0]  prod_r, prod_nxt;
  logic [CW-1:0]         hx_r, hx_nxt, hy_r, hy_nxt;
  logic [SW-1:0]         sum_r, sum_nxt;
  logic [RW-1:0]         root_r, root_nxt;
  logic [RRW-1:0]        rrem_r, rrem_nxt;
  logic                  ov_r, ov_nxt;
  logic                  of_r, of_nxt;
  logic [ID_BITS-1:0]    oid_r, oid_nxt;
  logic [TF:0]           ot_r, ot_nxt;
  logic [CW-1:0]         ox_r, ox_nxt, oy_r, oy_nxt;
  logic [DW-1:0]         od_r, od_nxt;

  // shared combinational terms
  logic signed [DW-1:0]  dx, dy, s_sel, d_sel, e_sel, num;
  logic signed [CW-1:0]  plo, phi, ps;
  logic [DW-1:0]         num_mag, d_mag;
  logic [NW-1:0]         n_full;
  logic [CW-2:0]         n_top;
  logic                  d_zero, par_fail, imm, ovf;
  logic signed [TW-1:0]  t_imm;
  logic [RMW-1:0]        rem2;
  logic                  dge, div_last, root_last;
  logic [QB-1:0]         quo_fin;
  logic signed [TW-1:0]  t_div;
  logic signed [TW-1:0]  lo_t, hi_t, tmin_s, tmax_s;
  logic                  slab_fail, cand, box_take, in_acc, out_free;
  logic [RRW-1:0]        rr2, trial;
  logic                  rge;
  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]  prod_sh;

  assign in_acc   = in_valid & ~in_stall;
  assign in_stall = (state_r != sbnh_pkg::ST_IDLE);
  assign out_free = ~ov_r | ~out_stall;
  assign box_take = in_box_enabled & ((in_box_layer & layer_r) != 8'd0);

  assign dx = $signed({ex_r[CW-1], ex_r}) - $signed({sx_r[CW-1], sx_r});
  assign dy = $signed({ey_r[CW-1], ey_r}) - $signed({sy_r[CW-1], sy_r});

  always_comb begin
    case (k_r)
      2'd0:    e_sel = $signed({bminx_r[CW-1], bminx_r});
      2'd1:    e_sel = $signed({bmaxx_r[CW-1], bmaxx_r});
      2'd2:    e_sel = $signed({bminy_r[CW-1], bminy_r});
      default: e_sel = $signed({bmaxy_r[CW-1], bmaxy_r});
    endcase
  end

  assign s_sel = k_r[1] ? $signed({sy_r[CW-1], sy_r}) : $signed({sx_r[CW-1], sx_r});
  assign d_sel = k_r[1] ? dy : dx;
  assign ps    = k_r[1] ? $signed(sy_r) : $signed(sx_r);
  assign plo   = k_r[1] ? bminy_r : bminx_r;
  assign phi   = k_r[1] ? bmaxy_r : bmaxx_r;

  assign num      = e_sel - s_sel;
  assign num_mag  = num[DW-1] ? DW'(-num) : DW'(num);
  assign d_mag    = d_sel[DW-1] ? DW'(-d_sel) : DW'(d_sel);
  assign n_full   = {num_mag, {TF{1'b0}}};
  assign n_top    = n_full[NW-1:QB];
  assign d_zero   = (d_sel == '0);
  assign par_fail = (ps < plo) || (ps > phi);
  assign ovf      = (DW'(n_top) >= d_mag);
  assign imm      = (num == '0) || (num[DW-1] != d_sel[DW-1]) || ovf;

  always_comb begin
    if (num == '0) begin
      t_imm = T_ZERO;
    end else if (num[DW-1] != d_sel[DW-1]) begin
      t_imm = T_NEG;
    end else begin
      t_imm = T_SAT;
    end
  end

  assign rem2     = {rem_r[RMW-2:0], low_r[QB-1]};
  assign dge      = (rem2 >= {1'b0, dd_r});
  assign quo_fin  = {quo_r[QB-2:0], dge};
  assign t_div    = ($signed({1'b0, quo_fin}) > T_SAT) ? T_SAT : $signed({1'b0, quo_fin});
  assign div_last = (cnt_r == CNTW'(1));

  assign lo_t      = (t1_r > t2_r) ? t2_r : t1_r;
  assign hi_t      = (t1_r > t2_r) ? t1_r : t2_r;
  assign tmin_s    = (lo_t > tmin_r) ? lo_t : tmin_r;
  assign tmax_s    = (hi_t < tmax_r) ? hi_t : tmax_r;
  assign slab_fail = (tmin_s > tmax_s);
  assign cand      = ok_r && (tmin_r < best_t_r);

  assign rr2       = {rrem_r[RRW-3:0], sum_r[SW-1:SW-2]};
  assign trial     = {root_r, 2'b01};
  assign rge       = (rr2 >= trial);
  assign root_last = (cnt_r == CNTW'(1));

  assign prod_sh = prod_r >>> TF;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sbnh_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = box_take ? sbnh_pkg::ST_PREP : sbnh_pkg::ST_DECIDE;
        end
      end
      sbnh_pkg::ST_PREP: begin
        if (d_zero) begin
          if (par_fail || k_r[1]) begin
            state_nxt = sbnh_pkg::ST_DECIDE;
          end
        end else begin
          state_nxt = imm ? sbnh_pkg::ST_STORE : sbnh_pkg::ST_DIV;
        end
      end
      sbnh_pkg::ST_DIV: begin
        if (div_last) begin
          state_nxt = sbnh_pkg::ST_STORE;
        end
      end
      sbnh_pkg::ST_STORE: begin
        state_nxt = k_r[0] ? sbnh_pkg::ST_SLAB : sbnh_pkg::ST_PREP;
      end
      sbnh_pkg::ST_SLAB: begin
        state_nxt = (slab_fail || k_r[1]) ? sbnh_pkg::ST_DECIDE : sbnh_pkg::ST_PREP;
      end
      sbnh_pkg::ST_DECIDE: begin
        if (!last_r) begin
          state_nxt = sbnh_pkg::ST_IDLE;
        end else if (cand || best_valid_r) begin
          state_nxt = sbnh_pkg::ST_MX;
        end else begin
          state_nxt = sbnh_pkg::ST_FIN;
        end
      end
      sbnh_pkg::ST_MX:    state_nxt = sbnh_pkg::ST_MY;
      sbnh_pkg::ST_MY:    state_nxt = sbnh_pkg::ST_SQX;
      sbnh_pkg::ST_SQX:   state_nxt = sbnh_pkg::ST_SQY;
      sbnh_pkg::ST_SQY:   state_nxt = sbnh_pkg::ST_RINIT;
      sbnh_pkg::ST_RINIT: state_nxt = sbnh_pkg::ST_ROOT;
      sbnh_pkg::ST_ROOT: begin
        if (root_last) begin
          state_nxt = sbnh_pkg::ST_MD;
        end
      end
      sbnh_pkg::ST_MD:    state_nxt = sbnh_pkg::ST_FIN;
      sbnh_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = sbnh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sbnh_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    k_nxt          = k_r;
    cnt_nxt        = cnt_r;
    bminx_nxt      = bminx_r;
    bminy_nxt      = bminy_r;
    bmaxx_nxt      = bmaxx_r;
    bmaxy_nxt      = bmaxy_r;
    id_nxt         = id_r;
    last_nxt       = last_r;
    ok_nxt         = ok_r;
    t1_nxt         = t1_r;
    t2_nxt         = t2_r;
    tres_nxt       = tres_r;
    tmin_nxt       = tmin_r;
    tmax_nxt       = tmax_r;
    dd_nxt         = dd_r;
    rem_nxt        = rem_r;
    low_nxt        = low_r;
    quo_nxt        = quo_r;
    best_t_nxt     = best_t_r;
    best_id_nxt    = best_id_r;
    best_valid_nxt = best_valid_r;
    prod_nxt       = prod_r;
    hx_nxt         = hx_r;
    hy_nxt         = hy_r;
    sum_nxt        = sum_r;
    root_nxt       = root_r;
    rrem_nxt       = rrem_r;
    ov_nxt         = ov_r & out_stall;
    of_nxt         = of_r;
    oid_nxt        = oid_r;
    ot_nxt         = ot_r;
    ox_nxt         = ox_r;
    oy_nxt         = oy_r;
    od_nxt         = od_r;
    mul_a          = MW'(dx);
    mul_b          = $signed(MW'({1'b0, best_t_r[TF:0]}));
    case (state_r)
      sbnh_pkg::ST_IDLE: begin
        if (in_acc) begin
          bminx_nxt = in_box_min_x;
          bminy_nxt = in_box_min_y;
          bmaxx_nxt = in_box_max_x;
          bmaxy_nxt = in_box_max_y;
          id_nxt    = in_box_id;
          last_nxt  = in_last_box;
          ok_nxt    = box_take;
          tmin_nxt  = T_ZERO;
          tmax_nxt  = T_ONE;
          k_nxt     = 2'd0;
        end
      end
      sbnh_pkg::ST_PREP: begin
        if (d_zero) begin
          if (par_fail) begin
            ok_nxt = 1'b0;
          end
          k_nxt = 2'd2;
        end else begin
          tres_nxt = t_imm;
          rem_nxt  = RMW'(n_top);
          low_nxt  = n_full[QB-1:0];
          quo_nxt  = '0;
          dd_nxt   = d_mag;
          cnt_nxt  = CNTW'(QB);
        end
      end
      sbnh_pkg::ST_DIV: begin
        rem_nxt = dge ? (rem2 - {1'b0, dd_r}) : rem2;
        low_nxt = {low_r[QB-2:0], 1'b0};
        quo_nxt = quo_fin;
        cnt_nxt = cnt_r - CNTW'(1);
        if (div_last) begin
          tres_nxt = t_div;
        end
      end
      sbnh_pkg::ST_STORE: begin
        if (k_r[0]) begin
          t2_nxt = tres_r;
        end else begin
          t1_nxt = tres_r;
          k_nxt  = k_r + 2'd1;
        end
      end
      sbnh_pkg::ST_SLAB: begin
        tmin_nxt = tmin_s;
        tmax_nxt = tmax_s;
        k_nxt    = 2'd2;
        if (slab_fail) begin
          ok_nxt = 1'b0;
        end
      end
      sbnh_pkg::ST_DECIDE: begin
        if (cand) begin
          best_t_nxt     = tmin_r;
          best_id_nxt    = id_r;
          best_valid_nxt = 1'b1;
        end
      end
      sbnh_pkg::ST_MX: begin
        prod_nxt = mul_a * mul_b;
      end
      sbnh_pkg::ST_MY: begin
        hx_nxt   = prod_sh[CW-1:0] + sx_r;
        mul_a    = MW'(dy);
        prod_nxt = mul_a * mul_b;
      end
      sbnh_pkg::ST_SQX: begin
        hy_nxt   = prod_sh[CW-1:0] + sy_r;
        mul_b    = MW'(dx);
        prod_nxt = mul_a * mul_b;
      end
      sbnh_pkg::ST_SQY: begin
        sum_nxt  = prod_r[SW-1:0];
        mul_a    = MW'(dy);
        mul_b    = MW'(dy);
        prod_nxt = mul_a * mul_b;
      end
      sbnh_pkg::ST_RINIT: begin
        sum_nxt  = sum_r + prod_r[SW-1:0];
        root_nxt = '0;
        rrem_nxt = '0;
        cnt_nxt  = CNTW'(RW);
      end
      sbnh_pkg::ST_ROOT: begin
        rrem_nxt = rge ? (rr2 - trial) : rr2;
        root_nxt = {root_r[RW-2:0], rge};
        sum_nxt  = {sum_r[SW-3:0], 2'b00};
        cnt_nxt  = cnt_r - CNTW'(1);
      end
      sbnh_pkg::ST_MD: begin
        mul_a    = $signed(MW'(root_r));
        prod_nxt = mul_a * mul_b;
      end
      sbnh_pkg::ST_FIN: begin
        if (out_free) begin
          ov_nxt         = 1'b1;
          of_nxt         = best_valid_r;
          oid_nxt        = best_valid_r ? best_id_r : '0;
          ot_nxt         = best_valid_r ? best_t_r[TF:0] : '0;
          ox_nxt         = best_valid_r ? hx_r : '0;
          oy_nxt         = best_valid_r ? hy_r : '0;
          od_nxt         = best_valid_r ? prod_sh[DW-1:0] : '0;
          best_t_nxt     = T_TWO;
          best_id_nxt    = '0;
          best_valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sbnh_pkg::ST_IDLE;
      best_t_r     <= T_TWO;
      best_id_r    <= '0;
      best_valid_r <= 1'b0;
      ov_r         <= 1'b0;
      k_r          <= '0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      best_t_r     <= best_t_nxt;
      best_id_r    <= best_id_nxt;
      best_valid_r <= best_valid_nxt;
      ov_r         <= ov_nxt;
      k_r          <= k_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bminx_r <= bminx_nxt;
    bminy_r <= bminy_nxt;
    bmaxx_r <= bmaxx_nxt;
    bmaxy_r <= bmaxy_nxt;
    id_r    <= id_nxt;
    last_r  <= last_nxt;
    ok_r    <= ok_nxt;
    t1_r    <= t1_nxt;
    t2_r    <= t2_nxt;
    tres_r  <= tres_nxt;
    tmin_r  <= tmin_nxt;
    tmax_r  <= tmax_nxt;
    dd_r    <= dd_nxt;
    rem_r   <= rem_nxt;
    low_r   <= low_nxt;
    quo_r   <= quo_nxt;
    prod_r  <= prod_nxt;
    hx_r    <= hx_nxt;
    hy_r    <= hy_nxt;
    sum_r   <= sum_nxt;
    root_r  <= root_nxt;
    rrem_r  <= rrem_nxt;
    of_r    <= of_nxt;
    oid_r   <= oid_nxt;
    ot_r    <= ot_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    od_r    <= od_nxt;
  end

  assign out_valid        = ov_r;
  assign out_hit_found    = of_r;
  assign out_hit_id       = oid_r;
  assign out_hit_t        = ot_r;
  assign out_hit_x        = $signed(ox_r);
  assign out_hit_y        = $signed(oy_r);
  assign out_hit_distance = od_r;

endmodule
`default_nettype wire

### design/sbnh_checker.sv
`default_nettype none
`include "segment_box_nearest_hit_macros.svh"
module sbnh_checker #(
  parameter int COORD_BITS  = 24,
  parameter int T_FRAC_BITS = 16,
  parameter int ID_BITS     = 16
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic                         out_hit_found,
  input wire logic [ID_BITS-1:0]           out_hit_id,
  input wire logic [T_FRAC_BITS:0]         out_hit_t,
  input wire logic signed [COORD_BITS-1:0] out_hit_x,
  input wire logic signed [COORD_BITS-1:0] out_hit_y,
  input wire logic [COORD_BITS:0]          out_hit_distance
);

  `SBNH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `SBNH_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_hit_t) && $stable(out_hit_id))
  `SBNH_ASSERT_IMPLY(a_miss_zero, out_valid && !out_hit_found, out_hit_id == '0 && out_hit_t == '0 && out_hit_x == '0 && out_hit_y == '0 && out_hit_distance == '0)
  `SBNH_ASSERT_IMPLY(a_t_range, out_valid && out_hit_t[T_FRAC_BITS], out_hit_t[T_FRAC_BITS-1:0] == '0)

endmodule

bind segment_box_nearest_hit sbnh_checker #(
  .COORD_BITS(COORD_BITS),
  .T_FRAC_BITS(T_FRAC_BITS),
  .ID_BITS(ID_BITS)
) u_sbnh_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_hit_found(out_hit_found),
  .out_hit_id(out_hit_id),
  .out_hit_t(out_hit_t),
  .out_hit_x(out_hit_x),
  .out_hit_y(out_hit_y),
  .out_hit_distance(out_hit_distance)
);
`default_nettype wire

### sim/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 24;
  localparam int TF = 16;
  localparam int IB = 16;
  localparam int AW = sbnh_pkg::CFG_ADDR_BITS;
  localparam longint T_ONE = 64'sd1 << TF;
  localparam int STALL_LIMIT = 20000;
  localparam int N_RANDOM = 900;

  typedef struct {
    logic signed [CB-1:0] min_x, min_y, max_x, max_y;
    logic [7:0]           layer;
    logic                 enabled;
    logic [IB-1:0]        id;
    logic                 last;
  } box_word_t;

  typedef struct {
    logic                 found;
    logic [IB-1:0]        id;
    logic [TF:0]          t;
    logic signed [CB-1:0] x, y;
    logic [CB:0]          distance;
  } hit_word_t;

  typedef struct {
    box_word_t box;
    logic      fixed;
    hit_word_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] in_box_min_x = '0, in_box_min_y = '0;
  logic signed [CB-1:0] in_box_max_x = '0, in_box_max_y = '0;
  logic [7:0] in_box_layer = '0;
  logic in_box_enabled = 1'b0;
  logic [IB-1:0] in_box_id = '0;
  logic in_last_box = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit_found;
  logic [IB-1:0] out_hit_id;
  logic [TF:0] out_hit_t;
  logic signed [CB-1:0] out_hit_x, out_hit_y;
  logic [CB:0] out_hit_distance;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  segment_box_nearest_hit uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  longint seg_sx, seg_sy, seg_ex, seg_ey;
  logic [7:0] layer_mask;
  longint near_t;
  logic [IB-1:0] near_id;
  logic near_valid;

  hit_word_t hits_due[$];
  int errors = 0;
  int boxes_in = 0;
  int hits_seen = 0;
  int found_seen = 0;
  int idle_cycles = 0;
  bit timed_out = 0;

  function automatic longint floor_quot(longint n, longint d);
    longint q, r;
    q = n / d;
    r = n % d;
    if (r != 0 && ((r < 0) != (d < 0))) q--;
    return q;
  endfunction

  function automatic longint clip_t(longint t);
    if (t < -1) return -1;
    if (t > T_ONE + 1) return T_ONE + 1;
    return t;
  endfunction

  function automatic bit slab_pass(longint s, longint lo, longint hi, longint d,
                                   inout longint tmin, inout longint tmax);
    longint t1, t2, tmp;
    if (d == 0) return !(s < lo || s > hi);
    t1 = clip_t(floor_quot((lo - s) * T_ONE, d));
    t2 = clip_t(floor_quot((hi - s) * T_ONE, d));
    if (t1 > t2) begin
      tmp = t1; t1 = t2; t2 = tmp;
    end
    if (t1 > tmin) tmin = t1;
    if (t2 < tmax) tmax = t2;
    return tmin <= tmax;
  endfunction

  function automatic logic [63:0] length_root(longint dx, longint dy);
    logic [127:0] sq, m2;
    logic [63:0] lo, hi, mid;
    sq = 128'(dx * dx) + 128'(dy * dy);
    lo = 0;
    hi = 64'd1 << 35;
    while (lo + 1 < hi) begin
      mid = lo + ((hi - lo) >> 1);
      m2 = 128'(mid) * 128'(mid);
      if (m2 <= sq) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic hit_word_t nearest_box_step(box_word_t b, output bit emits);
    hit_word_t h;
    longint dx, dy, tmin, tmax, t;
    logic [63:0] len;
    h = '{default: '0};
    dx = seg_ex - seg_sx;
    dy = seg_ey - seg_sy;
    if (b.enabled && (b.layer & layer_mask) != 0) begin
      tmin = 0;
      tmax = T_ONE;
      if (slab_pass(seg_sx, b.min_x, b.max_x, dx, tmin, tmax) &&
          slab_pass(seg_sy, b.min_y, b.max_y, dy, tmin, tmax) && tmin < near_t) begin
        near_t = tmin;
        near_id = b.id;
        near_valid = 1'b1;
      end
    end
    emits = b.last;
    if (!b.last) return h;
    if (near_valid) begin
      t = near_t;
      len = length_root(dx, dy);
      h.found = 1'b1;
      h.id = near_id;
      h.t = t[TF:0];
      h.x = CB'(seg_sx + floor_quot(dx * t, T_ONE));
      h.y = CB'(seg_sy + floor_quot(dy * t, T_ONE));
      h.distance = (CB+1)'((64'(t) * len) >> TF);
    end
    near_t = 2 * T_ONE;
    near_id = '0;
    near_valid = 1'b0;
    return h;
  endfunction

  task automatic reg_write(sbnh_pkg::reg_idx_t idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= AW'(4 * int'(idx));
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      sbnh_pkg::REG_START_X: seg_sx = longint'($signed(val[CB-1:0]));
      sbnh_pkg::REG_START_Y: seg_sy = longint'($signed(val[CB-1:0]));
      sbnh_pkg::REG_END_X:   seg_ex = longint'($signed(val[CB-1:0]));
      sbnh_pkg::REG_END_Y:   seg_ey = longint'($signed(val[CB-1:0]));
      sbnh_pkg::REG_LAYER:   layer_mask = val[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_segment(longint sx, longint sy, longint ex, longint ey,
                             logic [7:0] mask);
    reg_write(sbnh_pkg::REG_START_X, 32'(sx));
    reg_write(sbnh_pkg::REG_START_Y, 32'(sy));
    reg_write(sbnh_pkg::REG_END_X, 32'(ex));
    reg_write(sbnh_pkg::REG_END_Y, 32'(ey));
    reg_write(sbnh_pkg::REG_LAYER, {24'd0, mask});
  endtask

  task automatic settle;
    while (hits_due.size() != 0 && !timed_out) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic send_box(box_word_t b, logic fixed, hit_word_t want);
    bit emits;
    hit_word_t h;
    in_box_min_x <= b.min_x;
    in_box_min_y <= b.min_y;
    in_box_max_x <= b.max_x;
    in_box_max_y <= b.max_y;
    in_box_layer <= b.layer;
    in_box_enabled <= b.enabled;
    in_box_id <= b.id;
    in_last_box <= b.last;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall && !timed_out) @(posedge clk);
    h = nearest_box_step(b, emits);
    if (fixed) h = want;
    if (emits) hits_due = {hits_due, h};
    boxes_in++;
    @(negedge clk);
  endtask

  int gap_left = 0;
  int burst_left = 0;

  task automatic pace;
    if (burst_left == 0) begin
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        repeat (gap_left) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  function automatic logic signed [CB-1:0] rand_coord(int span);
    if ($urandom_range(0, 9) == 0) return CB'($urandom);
    return CB'($signed(int'($urandom_range(0, 2 * span))) - span);
  endfunction

  function automatic box_word_t rand_box(bit last);
    box_word_t b;
    logic signed [CB-1:0] a, c;
    a = rand_coord(6000);
    c = rand_coord(6000);
    b.min_x = a;
    b.max_x = ($urandom_range(0, 15) == 0) ? a - CB'($urandom_range(0, 500))
                                           : a + CB'($urandom_range(0, 3000));
    b.min_y = c;
    b.max_y = ($urandom_range(0, 15) == 0) ? c - CB'($urandom_range(0, 500))
                                           : c + CB'($urandom_range(0, 3000));
    b.layer = 8'($urandom);
    b.enabled = ($urandom_range(0, 7) != 0);
    b.id = IB'($urandom);
    b.last = last;
    return b;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      hit_word_t w;
      if (hits_due.size() == 0) begin
        $display("%0t: unexpected result id=%0d", $time, out_hit_id);
        errors++;
      end else begin
        w = hits_due.pop_front();
        hits_seen++;
        if (out_hit_found) found_seen++;
        if (out_hit_found !== w.found || out_hit_id !== w.id || out_hit_t !== w.t ||
            out_hit_x !== w.x || out_hit_y !== w.y || out_hit_distance !== w.distance) begin
          $display("%0t: mismatch exp f=%0d id=%0d t=%0d x=%0d y=%0d d=%0d", $time,
                   w.found, w.id, w.t, w.x, w.y, w.distance);
          $display("%0t:          got f=%0d id=%0d t=%0d x=%0d y=%0d d=%0d", $time,
                   out_hit_found, out_hit_id, out_hit_t, out_hit_x, out_hit_y,
                   out_hit_distance);
          errors++;
        end
      end
    end
  end

  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[9]) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("%0t: watchdog expired", $time);
      $display("** segment_box_nearest_hit: FAILED **");
      $finish;
    end
  end

  localparam logic signed [CB-1:0] CMAX = 24'sh7fffff;
  localparam logic signed [CB-1:0] CMIN = -24'sh800000;

  stim_row_t directed[] = '{
    // empty query straight after reset
    '{'{0, 0, 0, 0, 8'hff, 1'b0, 16'h1234, 1'b1}, 1'b1, '{default: '0}},
    // degenerate segment at origin: containing box gives t 0
    '{'{-10, -10, 10, 10, 8'h01, 1'b1, 16'hffff, 1'b1}, 1'b1,
      '{1'b1, 16'hffff, '0, '0, '0, '0}},
    '{'{CMIN, CMIN, CMAX, CMAX, 8'h80, 1'b1, 16'h0000, 1'b1}, 1'b1,
      '{1'b1, 16'h0000, '0, '0, '0, '0}},
    // box off the start point on a parallel axis
    '{'{5, 5, 9, 9, 8'hff, 1'b1, 16'd7, 1'b1}, 1'b1, '{default: '0}},
    // inverted box rejected on parallel axes
    '{'{10, 10, -10, -10, 8'hff, 1'b1, 16'd8, 1'b1}, 1'b1, '{default: '0}}
  };

  stim_row_t sloped[] = '{
    '{'{1000, -500, 2000, 500, 8'h01, 1'b1, 16'd1, 1'b0}, 1'b0, '{default: '0}},
    '{'{1000, -500, 2000, 500, 8'h02, 1'b1, 16'd2, 1'b0}, 1'b0, '{default: '0}},
    '{'{500, -100, 600, 100, 8'h00, 1'b1, 16'd3, 1'b0}, 1'b0, '{default: '0}},
    '{'{500, -100, 600, 100, 8'hff, 1'b0, 16'd4, 1'b0}, 1'b0, '{default: '0}},
    '{'{2000, 500, 1000, -500, 8'hff, 1'b1, 16'd5, 1'b1}, 1'b0, '{default: '0}},
    '{'{CMIN, CMIN, CMAX, CMAX, 8'hff, 1'b1, 16'hffff, 1'b0}, 1'b0, '{default: '0}},
    '{'{-100, -100, 100, 100, 8'h01, 1'b1, 16'd9, 1'b0}, 1'b0, '{default: '0}},
    '{'{4000, 4000, 4100, 4100, 8'h01, 1'b1, 16'd10, 1'b1}, 1'b0, '{default: '0}},
    '{'{4095, 0, 9000, 10, 8'h01, 1'b1, 16'd11, 1'b1}, 1'b0, '{default: '0}},
    '{'{100, 100, 200, 200, 8'h01, 1'b1, 16'd12, 1'b1}, 1'b0, '{default: '0}}
  };

  initial begin
    int nq, len;
    seg_sx = 0; seg_sy = 0; seg_ex = 0; seg_ey = 0;
    layer_mask = 8'hff;
    near_t = 2 * T_ONE; near_id = '0; near_valid = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) send_box(directed[i].box, directed[i].fixed, directed[i].want);
    in_valid <= 1'b0;
    settle();
    set_segment(0, 0, 4096, 0, 8'h01);
    foreach (sloped[i]) send_box(sloped[i].box, sloped[i].fixed, sloped[i].want);
    in_valid <= 1'b0;
    settle();
    set_segment(CMIN, CMAX, CMAX, CMIN, 8'hff);
    send_box('{CMIN, CMIN, CMAX, CMAX, 8'hff, 1'b1, 16'd13, 1'b1}, 1'b0, '{default: '0});
    send_box('{-200, -200, 200, 200, 8'hff, 1'b1, 16'd14, 1'b1}, 1'b0, '{default: '0});
    in_valid <= 1'b0;
    settle();
    nq = 0;
    while (boxes_in < N_RANDOM + 30) begin
      if (nq % 40 == 0) begin
        in_valid <= 1'b0;
        settle();
        case ($urandom_range(0, 3))
          0: set_segment(rand_coord(8000), rand_coord(8000), rand_coord(8000),
                         rand_coord(8000), 8'($urandom));
          1: set_segment(rand_coord(3000), 0, rand_coord(3000), 0, 8'hff);
          2: set_segment(0, rand_coord(3000), 0, rand_coord(3000), 8'($urandom));
          default: set_segment(CB'($urandom), CB'($urandom), CB'($urandom),
                               CB'($urandom), 8'($urandom_range(0, 1) ? 8'hff : 8'h00));
        endcase
      end
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        pace();
        send_box(rand_box(k == len - 1), 1'b0, '{default: '0});
      end
      nq++;
    end
    in_valid <= 1'b0;
    settle();
    $display("boxes sent %0d, results checked %0d (%0d with a hit)", boxes_in, hits_seen,
             found_seen);
    $display("segments covered: degenerate, axis-parallel, extremes and random");
    if (errors == 0 && hits_due.size() == 0) begin
      $display("** segment_box_nearest_hit: PASSED **");
    end else begin
      $display("** segment_box_nearest_hit: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire
